// ===== rtl/core/tmbc_pkg.sv =====
package tmbc_pkg;

  // fixed widths of the queue entry and the region math
  localparam int CW        = 13;  // byte column / tile row index
  localparam int BASEW     = 27;  // row base address
  localparam int EXW       = 36;  // tile edge arithmetic, doubled units
  localparam int DIVW      = 26;  // divider dividend magnitude
  localparam int REGW      = 28;  // signed region bounds before clamping
  localparam int QDEPTH    = 2;
  localparam int QPW       = 1;

  // input word codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_RADIUS_X  = 2'd0;
  localparam logic [1:0] CFG_RADIUS_Y  = 2'd1;
  localparam logic [1:0] CFG_MAP_PITCH = 2'd2;
  localparam logic [1:0] CFG_MAP_ROWS  = 2'd3;

  localparam logic [3:0] TILE_SOLID = 4'd1;

  localparam logic [3:0] FLAG_LEFT  = 4'b0001;
  localparam logic [3:0] FLAG_RIGHT = 4'b0010;
  localparam logic [3:0] FLAG_FLOOR = 4'b0100;
  localparam logic [3:0] FLAG_CEIL  = 4'b1000;

  typedef struct packed {
    logic               cmd;
    logic [11:0]        map_addr;
    logic [7:0]         map_byte;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
  } in_t;

  typedef struct packed {
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic [3:0]         hit_flags;
  } out_t;

  typedef struct packed {
    logic [15:0] radius_x;
    logic [15:0] radius_y;
    logic [12:0] map_pitch;
    logic [12:0] map_rows;
  } cfg_t;

  // one queued command: a map write or a classified query
  typedef struct packed {
    logic               is_query;
    logic               empty;
    logic [11:0]        waddr;
    logic [7:0]         wbyte;
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic [CW-1:0]      lb;
    logic [CW-1:0]      rb;
    logic [CW-1:0]      top;
    logic [CW-1:0]      bot;
    logic [BASEW-1:0]   base;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_CALC,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD,
    B_CAP,
    B_HX,
    B_HY,
    B_LX,
    B_LY,
    B_DONE
  } back_state_e;

  // clamp to the 24-bit signed position range
  function automatic logic signed [23:0] sat24(input logic signed [EXW-1:0] v);
    logic signed [EXW-1:0] hi;
    logic signed [EXW-1:0] lo;
    hi = EXW'(8388607);
    lo = EXW'(-8388608);
    if (v > hi) begin
      return 24'sh7FFFFF;
    end else if (v < lo) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

endpackage

// ===== rtl/core/tmbc_ram.sv =====
module tmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/tmbc_front.sv =====
module tmbc_front #(
  parameter int TILE_DIM  = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tmbc_pkg::in_t   in_word_i,
  input  tmbc_pkg::cfg_t  cfg_i,
  output logic            push_o,
  output tmbc_pkg::cmd_t  push_data_o,
  input  logic            full_i
);
  import tmbc_pkg::*;

  localparam logic [DIVW-1:0] CA_D = DIVW'((TILE_DIM - 1) << FRAC_BITS);
  // reciprocal of the tile width, exact for magnitudes below 2^(DIVW-1)
  localparam int RK = DIVW - 1 + $clog2(TILE_DIM);
  localparam int RW = DIVW + 1;
  localparam int PW = DIVW - 1 + RW;
  localparam logic [RW-1:0] RECIP =
    RW'(((longint'(1) << RK) + longint'(TILE_DIM) - 1) / longint'(TILE_DIM));

  front_state_e state_q, state_d;
  logic [1:0]      lane_q, lane_d;
  cmd_t            ent_q, ent_d;
  logic [DIVW-1:0] num_q [4];
  logic [DIVW-1:0] num_d [4];
  logic [DIVW-1:0] quo_q [4];
  logic [DIVW-1:0] quo_d [4];
  logic [3:0]      neg_q, neg_d;

  // dividends: left, right, top, bottom edges of the box
  logic [DIVW-1:0] dvd [4];
  always_comb begin
    dvd[0] = DIVW'(in_word_i.pos_x) - DIVW'(cfg_i.radius_x);
    dvd[1] = DIVW'(in_word_i.pos_x) + DIVW'(cfg_i.radius_x) + CA_D;
    dvd[2] = DIVW'(in_word_i.pos_y) - DIVW'(cfg_i.radius_y);
    dvd[3] = DIVW'(in_word_i.pos_y) + DIVW'(cfg_i.radius_y) + CA_D;
  end

  // region bounds from the quotients, truncated toward zero
  logic signed [REGW-1:0] lbv, rbv, topv, botv, pm1, rm1;
  always_comb begin
    lbv  = neg_q[0] ? '0 : $signed({3'b0, quo_q[0][DIVW-1:1]});
    rbv  = (neg_q[1] && quo_q[1] != '0) ? -REGW'(1) : $signed({3'b0, quo_q[1][DIVW-1:1]});
    topv = neg_q[2] ? '0 : $signed({2'b0, quo_q[2]});
    botv = (neg_q[3] && quo_q[3] != '0) ? -REGW'(1) : $signed({2'b0, quo_q[3]});
    pm1  = $signed({15'b0, cfg_i.map_pitch}) - REGW'(1);
    rm1  = $signed({15'b0, cfg_i.map_rows}) - REGW'(1);
    if (rbv > pm1) begin
      rbv = pm1;
    end
    if (botv > rm1) begin
      botv = rm1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
    ent_q  <= ent_d;
    neg_q  <= neg_d;
    for (int i = 0; i < 4; i++) begin
      num_q[i] <= num_d[i];
      quo_q[i] <= quo_d[i];
    end
  end

  always_comb begin
    logic [PW-1:0] prod;
    state_d    = state_q;
    lane_d     = lane_q;
    ent_d      = ent_q;
    neg_d      = neg_q;
    num_d      = num_q;
    quo_d      = quo_q;
    prod       = '0;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ent_d.waddr = in_word_i.map_addr;
          ent_d.wbyte = in_word_i.map_byte;
          ent_d.px    = in_word_i.pos_x;
          ent_d.py    = in_word_i.pos_y;
          if (in_word_i.cmd == CMD_QUERY) begin
            ent_d.is_query = 1'b1;
            lane_d         = '0;
            // magnitudes with the fraction bits already dropped
            for (int i = 0; i < 4; i++) begin
              neg_d[i] = dvd[i][DIVW-1];
              num_d[i] = (dvd[i][DIVW-1] ? -dvd[i] : dvd[i]) >> FRAC_BITS;
            end
            state_d = F_DIV;
          end else begin
            ent_d.is_query = 1'b0;
            state_d        = F_PUSH;
          end
        end
      end
      F_DIV: begin
        // divide by the tile width with a reciprocal multiply, one lane a cycle
        prod           = num_q[lane_q][DIVW-2:0] * RECIP;
        quo_d[lane_q]  = DIVW'(prod >> RK);
        lane_d         = lane_q + 2'd1;
        if (lane_q == 2'd3) begin
          state_d = F_CALC;
        end
      end
      F_CALC: begin
        ent_d.lb    = lbv[CW-1:0];
        ent_d.rb    = rbv[CW-1:0];
        ent_d.top   = topv[CW-1:0];
        ent_d.bot   = botv[CW-1:0];
        ent_d.empty = (lbv > rbv) || (topv > botv);
        state_d     = F_MUL;
      end
      F_MUL: begin
        ent_d.base = BASEW'(ent_q.top * cfg_i.map_pitch);
        state_d    = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  assign push_data_o = ent_q;

endmodule

// ===== rtl/core/tmbc_fifo.sv =====
module tmbc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tmbc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output tmbc_pkg::cmd_t data_o,
  output logic           empty_o
);
  import tmbc_pkg::*;

  cmd_t           mem_q [QDEPTH];
  logic [QPW-1:0] wptr_q, rptr_q;
  logic [QPW:0]   cnt_q;

  assign full_o  = cnt_q == (QPW + 1)'(QDEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (QPW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (QPW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/tmbc_back.sv =====
module tmbc_back #(
  parameter int TILE_DIM  = 16,
  parameter int MAP_BYTES = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tmbc_pkg::cfg_t cfg_i,
  input  tmbc_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tmbc_pkg::out_t out_word_o
);
  import tmbc_pkg::*;

  localparam int RAW = $clog2(MAP_BYTES);
  localparam int S   = TILE_DIM << FRAC_BITS;
  localparam logic signed [EXW-1:0] S_X  = EXW'(S);
  localparam logic signed [EXW-1:0] S2_X = EXW'(2 * S);

  back_state_e state_q, state_d;
  logic signed [23:0]    px_q, px_d, py_q, py_d;
  logic [3:0]            flags_q, flags_d;
  logic [CW-1:0]         col_q, col_d, row_q, row_d;
  logic [CW-1:0]         lb_q, lb_d, rb_q, rb_d, bot_q, bot_d;
  logic [BASEW-1:0]      base_q, base_d;
  logic signed [EXW-1:0] lx_q, lx_d, lxs_q, lxs_d, ty_q, ty_d;
  logic [7:0]            byte_q, byte_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  // map store port
  logic           ram_we;
  logic [31:0]    waddr32, raddr32;
  logic [BASEW:0] raddr;
  logic [7:0]     rdata;
  logic           rd_in_range;

  assign waddr32     = 32'(head_i.waddr);
  assign raddr       = {1'b0, base_q} + (BASEW + 1)'(col_q);
  assign raddr32     = 32'(raddr);
  assign rd_in_range = raddr32 < MAP_BYTES;

  tmbc_ram #(
    .WIDTH(8),
    .DEPTH(MAP_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr32[RAW-1:0]),
    .wdata_i(head_i.wbyte),
    .raddr_i(raddr32[RAW-1:0]),
    .rdata_o(rdata)
  );

  // tile push-out: x step with the current centre, y step with the moved x
  logic                  low, solid;
  logic [3:0]            code;
  logic signed [EXW-1:0] l_e, t_e, px_e, py_e, rx_e, ry_e;
  logic signed [EXW-1:0] l2, r2, cx2, t2, b2, cy2, px2, py2, rx2, ry2;
  logic signed [23:0]    px_t, py_t;
  logic [3:0]            fx, fy;

  always_comb begin
    low   = (state_q == B_LX) || (state_q == B_LY);
    code  = low ? byte_q[3:0] : byte_q[7:4];
    solid = code == TILE_SOLID;
    l_e   = lx_q + (low ? S_X : '0);
    t_e   = ty_q;
    px_e  = EXW'(px_q);
    py_e  = EXW'(py_q);
    rx_e  = $signed(EXW'(cfg_i.radius_x));
    ry_e  = $signed(EXW'(cfg_i.radius_y));
    l2    = l_e + l_e;
    r2    = l2 + S2_X;
    cx2   = l2 + S_X;
    t2    = t_e + t_e;
    b2    = t2 + S2_X;
    cy2   = t2 + S_X;
    px2   = px_e + px_e;
    py2   = py_e + py_e;
    rx2   = rx_e + rx_e;
    ry2   = ry_e + ry_e;
    px_t  = px_q;
    py_t  = py_q;
    fx    = '0;
    fy    = '0;
    if (solid && (py2 >= t2 - ry_e) && (py2 <= b2 + ry_e)) begin
      if (px2 < cx2) begin
        if (px2 >= l2 - rx2) begin
          px_t = sat24(l_e - rx_e);
          fx   = FLAG_RIGHT;
        end
      end else if (px2 <= r2 + rx2) begin
        px_t = sat24(l_e + S_X + rx_e);
        fx   = FLAG_LEFT;
      end
    end
    if (solid && (px2 >= l2 - rx_e) && (px2 <= r2 + rx_e)) begin
      if (py2 < cy2) begin
        if (py2 >= t2 - ry2) begin
          py_t = sat24(t_e - ry_e);
          fy   = FLAG_FLOOR;
        end
      end else if (py2 <= b2 + ry2) begin
        py_t = sat24(t_e + S_X + ry_e);
        fy   = FLAG_CEIL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    flags_q <= flags_d;
    col_q   <= col_d;
    row_q   <= row_d;
    lb_q    <= lb_d;
    rb_q    <= rb_d;
    bot_q   <= bot_d;
    base_q  <= base_d;
    lx_q    <= lx_d;
    lxs_q   <= lxs_d;
    ty_q    <= ty_d;
    byte_q  <= byte_d;
    out_q   <= out_d;
  end

  // sequencer: walk the region row by row, high nibble then low nibble
  always_comb begin
    state_d     = state_q;
    px_d        = px_q;
    py_d        = py_q;
    flags_d     = flags_q;
    col_d       = col_q;
    row_d       = row_q;
    lb_d        = lb_q;
    rb_d        = rb_q;
    bot_d       = bot_q;
    base_d      = base_q;
    lx_d        = lx_q;
    lxs_d       = lxs_q;
    ty_d        = ty_q;
    byte_d      = byte_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (!head_i.is_query) begin
            ram_we = waddr32 < MAP_BYTES;
          end else begin
            px_d    = head_i.px;
            py_d    = head_i.py;
            flags_d = '0;
            col_d   = head_i.lb;
            row_d   = head_i.top;
            lb_d    = head_i.lb;
            rb_d    = head_i.rb;
            bot_d   = head_i.bot;
            base_d  = head_i.base;
            lxs_d   = $signed(EXW'(head_i.lb)) * S2_X;
            lx_d    = $signed(EXW'(head_i.lb)) * S2_X;
            ty_d    = $signed(EXW'(head_i.top)) * S_X;
            state_d = head_i.empty ? B_DONE : B_RD;
          end
        end
      end
      B_RD: begin
        state_d = B_CAP;
      end
      B_CAP: begin
        byte_d  = rd_in_range ? rdata : 8'h00;
        state_d = B_HX;
      end
      B_HX: begin
        px_d    = px_t;
        flags_d = flags_q | fx;
        state_d = B_HY;
      end
      B_HY: begin
        py_d    = py_t;
        flags_d = flags_q | fy;
        state_d = B_LX;
      end
      B_LX: begin
        px_d    = px_t;
        flags_d = flags_q | fx;
        state_d = B_LY;
      end
      B_LY: begin
        py_d    = py_t;
        flags_d = flags_q | fy;
        if (col_q == rb_q) begin
          if (row_q == bot_q) begin
            state_d = B_DONE;
          end else begin
            row_d   = row_q + CW'(1);
            col_d   = lb_q;
            base_d  = base_q + BASEW'(cfg_i.map_pitch);
            ty_d    = ty_q + S_X;
            lx_d    = lxs_q;
            state_d = B_RD;
          end
        end else begin
          col_d   = col_q + CW'(1);
          lx_d    = lx_q + S2_X;
          state_d = B_RD;
        end
      end
      B_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.new_x     = px_q;
          out_d.new_y     = py_q;
          out_d.hit_flags = flags_q;
          out_valid_d     = 1'b1;
          state_d         = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== rtl/core/tile_map_box_collision_core.sv =====
// channel   direction  handshake                 word
// in        input      in_valid_i / in_ready_o   in_word_i  (map write or query)
// out       output     out_valid_o / out_ready_i out_word_o (one per query)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The front takes no new word until it has pushed the last; a query there runs
// four reciprocal multiplies for the region bounds and a multiply for the row base.
// The back part takes a write at once and per query does one map read and four tile
// steps per map byte covered. A 2-entry queue lets the two overlap. Reset clears
// control state and presets the config registers; the map store holds garbage
// until written. A full output register stalls the back, and a full queue the front.
module tile_map_box_collision_core #(
  parameter int TILE_DIM  = 16,
  parameter int MAP_BYTES = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tmbc_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tmbc_pkg::out_t out_word_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [15:0]    cfg_data_i
);
  import tmbc_pkg::*;

  cfg_t cfg_q;
  cmd_t push_data, head;
  logic push, full, pop, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius_x  <= 16'd2048;
      cfg_q.radius_y  <= 16'd2048;
      cfg_q.map_pitch <= 13'd64;
      cfg_q.map_rows  <= 13'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIUS_X:  cfg_q.radius_x  <= cfg_data_i;
        CFG_RADIUS_Y:  cfg_q.radius_y  <= cfg_data_i;
        CFG_MAP_PITCH: cfg_q.map_pitch <= cfg_data_i[12:0];
        CFG_MAP_ROWS:  cfg_q.map_rows  <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  tmbc_front #(
    .TILE_DIM (TILE_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .cfg_i      (cfg_q),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  tmbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head),
    .empty_o(empty)
  );

  tmbc_back #(
    .TILE_DIM (TILE_DIM),
    .MAP_BYTES(MAP_BYTES),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

endmodule

// ===== tb/tile_map_box_collision_checker.sv =====
module tile_map_box_collision_checker
  import tmbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_word_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_word_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          queries_o,
  output int          hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TileUnits = 16 << 8;
  localparam longint CeilAdd   = 15 << 8;
  localparam int     StoreSize = 4096;

  // shadow copy of the map and the registers
  logic [7:0]  map_shadow [StoreSize];
  logic [15:0] rad_x, rad_y;
  logic [12:0] pitch, rows;
  out_t        moved_q [$];

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // push the centre out of one solid tile, doubled units for half radii
  function automatic logic [3:0] push_tile(inout longint px, inout longint py,
                                           input longint rx, input longint ry,
                                           input longint tx, input longint ty);
    longint l2, r2, cx2, t2, b2, cy2;
    logic [3:0] f;
    l2 = 2 * tx * TileUnits;
    r2 = 2 * (tx + 1) * TileUnits;
    cx2 = (2 * tx + 1) * TileUnits;
    t2 = 2 * ty * TileUnits;
    b2 = 2 * (ty + 1) * TileUnits;
    cy2 = (2 * ty + 1) * TileUnits;
    f = '0;
    if (2 * py >= t2 - ry && 2 * py <= b2 + ry) begin
      if (2 * px < cx2) begin
        if (2 * px >= l2 - 2 * rx) begin
          px = clamp24(tx * TileUnits - rx);
          f |= FLAG_RIGHT;
        end
      end else if (2 * px <= r2 + 2 * rx) begin
        px = clamp24((tx + 1) * TileUnits + rx);
        f |= FLAG_LEFT;
      end
    end
    if (2 * px >= l2 - rx && 2 * px <= r2 + rx) begin
      if (2 * py < cy2) begin
        if (2 * py >= t2 - 2 * ry) begin
          py = clamp24(ty * TileUnits - ry);
          f |= FLAG_FLOOR;
        end
      end else if (2 * py <= b2 + 2 * ry) begin
        py = clamp24((ty + 1) * TileUnits + ry);
        f |= FLAG_CEIL;
      end
    end
    return f;
  endfunction

  // walk the covered bytes row by row, high nibble first
  function automatic out_t resolve_box(in_t w);
    longint px, py, rx, ry, tl, tr, lb, rb, top, bot, addr;
    logic [7:0] b;
    out_t r;
    px = longint'(w.pos_x);
    py = longint'(w.pos_y);
    rx = longint'(rad_x);
    ry = longint'(rad_y);
    r.hit_flags = '0;
    tl = (px - rx) / TileUnits;
    tr = (px + rx + CeilAdd) / TileUnits;
    lb = (tl < 0) ? 0 : tl / 2;
    rb = (tr < 0) ? -1 : tr / 2;
    top = (py - ry) / TileUnits;
    bot = (py + ry + CeilAdd) / TileUnits;
    if (top < 0) top = 0;
    if (rb > longint'(pitch) - 1) rb = longint'(pitch) - 1;
    if (bot > longint'(rows) - 1) bot = longint'(rows) - 1;
    for (longint row = top; row <= bot; row++) begin
      for (longint col = lb; col <= rb; col++) begin
        addr = row * longint'(pitch) + col;
        b = (addr >= 0 && addr < StoreSize) ? map_shadow[addr] : 8'h00;
        if (b[7:4] == TILE_SOLID)
          r.hit_flags |= push_tile(px, py, rx, ry, 2 * col, row);
        if (b[3:0] == TILE_SOLID)
          r.hit_flags |= push_tile(px, py, rx, ry, 2 * col + 1, row);
      end
    end
    r.new_x = px[23:0];
    r.new_y = py[23:0];
    return r;
  endfunction

  assign pending_o = moved_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_w;
    if (!rst_ni) begin
      rad_x = 16'd2048;
      rad_y = 16'd2048;
      pitch = 13'd64;
      rows = 13'd64;
      moved_q.delete();
      fail_count_o = 0;
      queries_o = 0;
      hits_o = 0;
    end else begin
      // results first, so a same-edge input never matches early
      if (out_valid_i && out_ready_i) begin
        if (moved_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected result word x=%0d y=%0d flags=%h", $realtime,
                     out_word_i.new_x, out_word_i.new_y, out_word_i.hit_flags);
        end else begin
          exp_w = moved_q.pop_front();
          if (out_word_i !== exp_w) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch exp x=%0d y=%0d flags=%h got x=%0d y=%0d flags=%h",
                       $realtime, exp_w.new_x, exp_w.new_y, exp_w.hit_flags,
                       out_word_i.new_x, out_word_i.new_y, out_word_i.hit_flags);
          end
          if (exp_w.hit_flags != '0) hits_o++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_word_i.cmd == CMD_WRITE) begin
          map_shadow[in_word_i.map_addr] = in_word_i.map_byte;
        end else begin
          moved_q.push_back(resolve_box(in_word_i));
          queries_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS_X:  rad_x = cfg_data_i;
          CFG_RADIUS_Y:  rad_y = cfg_data_i;
          CFG_MAP_PITCH: pitch = cfg_data_i[12:0];
          CFG_MAP_ROWS:  rows = cfg_data_i[12:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tile_map_box_collision_core_tb.sv =====
module tile_map_box_collision_core_tb;
  import tmbc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;
  localparam int DrainWait = 64;
  localparam int FillBytes = 256;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_word_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_word_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_RADIUS_X;
  logic [15:0] cfg_data_i = '0;

  int          fail_count, pending, queries, hits;
  idle_mode_e  idle_mode = IDLE_NONE;
  int          hold_off = 0;
  int          quiet_cycles = 0;
  int          words_sent = 0;
  int          cur_pitch = 64, cur_rows = 64;

  always #6 clk_i = ~clk_i;

  tile_map_box_collision_core DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_word_i,
    .out_valid_o, .out_ready_i, .out_word_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  tile_map_box_collision_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .in_word_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_word_i(out_word_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .queries_o(queries), .hits_o(hits)
  );

  // result side: random stalls plus requested long hold-offs
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready_i <= ($urandom_range(0, 99) >= 77);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready_i <= ($urandom_range(0, 99) >= 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("** tile_map_box_collision_core: FAILED **");
      $finish;
    end
  end

  task automatic send_word(in_t w);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 77 : (idle_mode == IDLE_BOTH) ? 14 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    // valid stays high; the next negedge either reloads or clears it
    fork
      begin
        @(negedge clk_i);
      end
    join_none
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic map_write(logic [11:0] a, logic [7:0] b);
    in_t w;
    w = '0;
    w.cmd = CMD_WRITE;
    w.map_addr = a;
    w.map_byte = b;
    w.pos_x = 24'($urandom);
    w.pos_y = 24'($urandom);
    send_word(w);
  endtask

  task automatic query(logic signed [23:0] x, logic signed [23:0] y);
    in_t w;
    w = '0;
    w.cmd = CMD_QUERY;
    w.map_addr = 12'($urandom);
    w.map_byte = 8'($urandom);
    w.pos_x = x;
    w.pos_y = y;
    send_word(w);
  endtask

  // wait for every result, then let trailing writes settle
  task automatic drain();
    stop_sending();
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int rx, int ry, int p, int r);
    set_reg(CFG_RADIUS_X, 16'(rx));
    set_reg(CFG_RADIUS_Y, 16'(ry));
    set_reg(CFG_MAP_PITCH, 16'(p));
    set_reg(CFG_MAP_ROWS, 16'(r));
    cur_pitch = p;
    cur_rows = r;
  endtask

  function automatic logic [7:0] tile_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 1)) b[7:4] = TILE_SOLID;
    if ($urandom_range(0, 1)) b[3:0] = TILE_SOLID;
    return b;
  endfunction

  // mostly positions around the live map, some anywhere
  function automatic logic signed [23:0] pick_pos(longint span);
    longint v;
    if ($urandom_range(0, 4) == 0) return 24'($urandom);
    v = longint'($urandom_range(0, 32'(span + 24576))) - 12288;
    if (v > 8388607) v = 8388607;
    return 24'(v);
  endfunction

  task automatic random_words(int n);
    int used;
    used = cur_pitch * cur_rows;
    if (used > FillBytes) used = FillBytes;
    repeat (n) begin
      if ($urandom_range(0, 99) < 40)
        map_write(12'($urandom_range(0, used - 1)), tile_byte());
      else
        query(pick_pos(longint'(cur_pitch) * 8192), pick_pos(longint'(cur_rows) * 4096));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the low map bytes get written before any query; larger maps also cover unwritten bytes
    for (int a = 0; a < FillBytes; a++) map_write(12'(a), tile_byte());

    // directed: defaults, map edges, exact tile hits, unsolid codes
    map_write(12'd0, 8'h11);
    map_write(12'd1, 8'h20);
    map_write(12'd65, 8'hF1);
    query(24'sd0, 24'sd0);
    query(24'sd4096, 24'sd2048);
    query(-24'sd8388608, -24'sd8388608);
    query(24'sd8388607, 24'sd8388607);
    query(24'sd12288, 24'sd6144);
    query(24'sd2048, -24'sd100);
    drain();

    // huge radii on a tiny map
    set_geometry(65535, 65535, 1, 4);
    query(24'sd0, 24'sd0);
    query(24'sd4000, 24'sd9000);
    drain();
    // zero radii
    set_geometry(0, 0, 2, 2);
    query(24'sd4096, 24'sd4096);
    query(24'sd2048, 24'sd6000);
    drain();

    // widest map: pushes near the top of the x range saturate
    set_geometry(2048, 2048, 4096, 4096);
    map_write(12'd1023, 8'h11);
    map_write(12'd1024, 8'h10);
    query(24'sd8388607, 24'sd100);
    query(24'sd8386000, 24'sd2048);
    drain();

    // random phases over geometries and idle patterns
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_geometry(2048, 2048, 16, 16);
        1: set_geometry(4096, 1024, 8, 32);
        2: set_geometry(0, 0, 1, 1);
        3: set_geometry(65535, 2048, 1, 3);
        4: set_geometry(300, 9000, 256, 1);
        5: set_geometry(16384, 16384, 8, 8);
        6: set_geometry($urandom_range(0, 6000), $urandom_range(0, 6000),
                        $urandom_range(1, 16), $urandom_range(1, 16));
        default: set_geometry(1, 65535, 2, 2);
      endcase
      idle_mode = idle_mode_e'(ph % 4);
      random_words(52);
      // long hold-off on the result side while words keep coming
      if (ph == 1 || ph == 5) hold_off = 400;
      random_words(52);
      drain();
    end

    $display("run: %0d words sent, %0d queries checked, %0d with contact", words_sent,
             queries, hits);
    $display("covered radius, pitch and row extremes under four handshake idle patterns");
    if (fail_count == 0) begin
      $display("** tile_map_box_collision_core: PASSED **");
    end else begin
      $display("** tile_map_box_collision_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== tile_map_box_collision_core.f =====
rtl/core/tmbc_pkg.sv
rtl/core/tmbc_ram.sv
rtl/core/tmbc_front.sv
rtl/core/tmbc_fifo.sv
rtl/core/tmbc_back.sv
rtl/core/tile_map_box_collision_core.sv
tb/tile_map_box_collision_checker.sv
tb/tile_map_box_collision_core_tb.sv
